/* sv/kcm_pkg.sv */
package kcm_pkg;

    localparam int KCM_QDEPTH = 2;

    localparam int KCM_KEY_W  = 32;
    localparam int KCM_DATA_W = 24;
    localparam int KCM_CFG_W  = 7;

    localparam logic [31:0] KCM_MAPPED_MASK = 32'h7F7F_7F7F;
    // Control buttons sit at bits 22, 14, 5 and 6.
    localparam logic [31:0] KCM_CTRL_MASK   = 32'h0040_4060;
    localparam logic [31:0] KCM_NOTE_MASK   = KCM_MAPPED_MASK & ~KCM_CTRL_MASK;

    localparam logic [7:0] KCM_ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] KCM_ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] KCM_ST_CTRL     = 8'hB0;

    localparam logic [1:0] KCM_REG_CHANNEL  = 2'd0;
    localparam logic [1:0] KCM_REG_VELOCITY = 2'd1;
    localparam logic [1:0] KCM_REG_LOWEST   = 2'd2;

    localparam logic [3:0] KCM_CHANNEL_RST  = 4'd0;
    localparam logic [6:0] KCM_VELOCITY_RST = 7'd64;
    localparam logic [6:0] KCM_LOWEST_RST   = 7'd48;

    localparam logic [6:0] KCM_NOTE_MAX = 7'h7F;

    typedef struct packed {
        logic [3:0] channel;
        logic [6:0] velocity;
        logic [6:0] lowest;
    } t_cfg;

    // One queued report: which keys produce a message and which mapped keys are down.
    typedef struct packed {
        logic [31:0] events;
        logic [31:0] down;
    } t_evt;

    typedef struct packed {
        logic       is_ctrl;
        logic [4:0] code;
    } t_key;

    function automatic t_key kcm_key_info(input logic [4:0] idx);
        t_key k;
        k.is_ctrl = 1'b0;
        k.code    = 5'd0;
        case (idx)
            5'd0:  k.code = 5'd19;
            5'd1:  k.code = 5'd20;
            5'd2:  k.code = 5'd21;
            5'd3:  k.code = 5'd22;
            5'd4:  k.code = 5'd23;
            5'd5:  begin k.is_ctrl = 1'b1; k.code = 5'd2; end
            5'd6:  begin k.is_ctrl = 1'b1; k.code = 5'd3; end
            5'd8:  k.code = 5'd13;
            5'd9:  k.code = 5'd14;
            5'd10: k.code = 5'd15;
            5'd11: k.code = 5'd16;
            5'd12: k.code = 5'd17;
            5'd13: k.code = 5'd18;
            5'd14: begin k.is_ctrl = 1'b1; k.code = 5'd1; end
            5'd16: k.code = 5'd7;
            5'd17: k.code = 5'd8;
            5'd18: k.code = 5'd9;
            5'd19: k.code = 5'd10;
            5'd20: k.code = 5'd11;
            5'd21: k.code = 5'd12;
            5'd22: begin k.is_ctrl = 1'b1; k.code = 5'd0; end
            5'd24: k.code = 5'd0;
            5'd25: k.code = 5'd1;
            5'd26: k.code = 5'd2;
            5'd27: k.code = 5'd3;
            5'd28: k.code = 5'd4;
            5'd29: k.code = 5'd5;
            5'd30: k.code = 5'd6;
            default: k.code = 5'd0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] kcm_onehot_idx(input logic [31:0] oh);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (oh[i]) begin
                idx = idx | 5'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* sv/key_change_to_midi_events_core.sv */
// The first message of a report passes through the queue, the pending-key register
// and the output register when the queue and back end are free.
// The back end takes a new report only once its pending keys are drained, and sends
// its messages in turn; reports with no message only update the kept keys.
// Reset (synchronous, active low) clears the kept keys and the queue and loads
// channel 0, velocity 64 and lowest note 48.
module key_change_to_midi_events_core import kcm_pkg::*; #(
    parameter int P_QDEPTH = KCM_QDEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] key_word
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] status_byte, [14:8] data_first,
                                     // [21:15] data_second, [23:22] zero
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata
);

    t_cfg r_cfg;
    t_evt w_push_evt;
    t_evt w_pop_evt;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel  <= KCM_CHANNEL_RST;
            r_cfg.velocity <= KCM_VELOCITY_RST;
            r_cfg.lowest   <= KCM_LOWEST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                KCM_REG_CHANNEL:  r_cfg.channel  <= i_cfg_wdata[3:0];
                KCM_REG_VELOCITY: r_cfg.velocity <= i_cfg_wdata;
                KCM_REG_LOWEST:   r_cfg.lowest   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    kcm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_evt      (w_push_evt)
    );

    kcm_queue #(
        .P_DEPTH (P_QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_push_evt),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_evt   (w_pop_evt)
    );

    kcm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (w_empty),
        .i_evt      (w_pop_evt),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

/* sv/kcm_front.sv */
module kcm_front import kcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,
    input  logic        i_full,
    output logic        o_push,
    output t_evt        o_evt
);

    logic [31:0] r_prev;
    logic [31:0] n_prev;
    logic [31:0] w_now;
    logic [31:0] w_chg;
    logic        w_acc;

    assign o_s_tready = ~i_full;
    assign w_acc      = i_s_tvalid & o_s_tready;
    assign w_now      = i_s_tdata & KCM_MAPPED_MASK;
    assign w_chg      = w_now ^ r_prev;

    // Notes report both edges; control buttons report presses only.
    assign o_evt.events = w_chg & (KCM_NOTE_MASK | (KCM_CTRL_MASK & w_now));
    assign o_evt.down   = w_now;
    assign o_push       = w_acc & (|o_evt.events);

    assign n_prev = w_acc ? w_now : r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else begin
            r_prev <= n_prev;
        end
    end

endmodule

/* sv/kcm_queue.sv */
module kcm_queue import kcm_pkg::*; #(
    parameter int P_DEPTH = KCM_QDEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_evt,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_evt o_evt
);

    localparam int PTR_W = $clog2(P_DEPTH);
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(P_DEPTH);

    t_evt             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_evt   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_FULL)
        else $error("queue count above depth");

    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> !o_empty)
        else $error("queue empty after a lone push");

    a_pop_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !i_push) |=> !o_full)
        else $error("queue full after a lone pop");

endmodule

/* sv/kcm_back.sv */
module kcm_back import kcm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_empty,
    input  t_evt        i_evt,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,
    output logic        o_m_tlast
);

    logic [31:0] r_pend;
    logic [31:0] r_down;
    logic        r_valid;
    logic [7:0]  r_status;
    logic [6:0]  r_first;
    logic [6:0]  r_second;
    logic        r_last;

    logic [31:0] n_pend;
    logic [31:0] w_low;
    logic [31:0] w_rest;
    logic [4:0]  w_idx;
    t_key        w_key;
    logic [7:0]  w_sum;
    logic [6:0]  w_note;
    logic [7:0]  w_base;
    logic        w_emit;
    logic        w_slot;

    // Lowest pending key first, one message per cycle while the output is not stalled.
    assign w_low  = r_pend & (~r_pend + 32'd1);
    assign w_rest = r_pend & ~w_low;
    assign w_idx  = kcm_onehot_idx(w_low);
    assign w_key  = kcm_key_info(w_idx);
    assign w_sum  = {1'b0, i_cfg.lowest} + {3'b000, w_key.code};
    assign w_note = w_sum[7] ? KCM_NOTE_MAX : w_sum[6:0];

    always_comb begin
        if (w_key.is_ctrl) begin
            w_base = KCM_ST_CTRL;
        end else if (|(r_down & w_low)) begin
            w_base = KCM_ST_NOTE_ON;
        end else begin
            w_base = KCM_ST_NOTE_OFF;
        end
    end

    assign w_slot = ~r_valid | i_m_tready;
    assign w_emit = (|r_pend) & w_slot;
    assign o_pop  = ~(|r_pend) & ~i_empty;

    always_comb begin
        n_pend = r_pend;
        if (o_pop) begin
            n_pend = i_evt.events;
        end else if (w_emit) begin
            n_pend = w_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (w_slot) begin
                r_valid <= |r_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_down <= i_evt.down;
        end
        if (w_emit) begin
            r_status <= w_base | {4'b0000, i_cfg.channel};
            r_first  <= w_key.is_ctrl ? {2'b00, w_key.code} : w_note;
            r_second <= i_cfg.velocity;
            r_last   <= ~(|w_rest);
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {2'b00, r_second, r_first, r_status};
    assign o_m_tlast  = r_last;

    a_onebit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> $countones(r_pend) == $countones($past(r_pend)) - 1)
        else $error("pending set did not lose exactly one key");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !(|w_rest)) |=> (r_pend == '0))
        else $error("pending keys left after the final message");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|r_pend) |-> !o_pop)
        else $error("new report taken while keys still pending");

endmodule

/* verif/testbench.sv */
module testbench;
    import kcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE     = 2'd3;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         HOLD_LEN      = 400;
    localparam int         STALL_LIMIT   = 20000;
    localparam int         PHASE_REPORTS = 55;

    typedef enum logic [1:0] {
        KEY_UNMAPPED,
        KEY_NOTE,
        KEY_BUTTON
    } key_kind_e;

    typedef struct packed {
        logic [7:0] status;
        logic [6:0] number;
        logic [6:0] value;
        logic       last;
    } midi_msg_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata   = '0;   // [31:0] key_word
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [23:0] o_m_tdata;          // [7:0] status_byte, [14:8] data_first,
                                     // [21:15] data_second, [23:22] zero
    logic        o_m_tlast;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_addr  = '0;
    logic [6:0]  i_cfg_wdata = '0;

    // Shadow copy of the block's registers and kept key state.
    logic [3:0]  cfg_channel  = KCM_CHANNEL_RST;
    logic [6:0]  cfg_velocity = KCM_VELOCITY_RST;
    logic [6:0]  cfg_lowest   = KCM_LOWEST_RST;
    logic [31:0] held_keys    = '0;

    midi_msg_t   midi_expected[$];
    logic [31:0] last_word     = '0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_start    = 1'b0;
    int          hold_left     = 0;
    int          idle_cycles   = 0;
    int          errors        = 0;
    int          reports_sent  = 0;
    int          msgs_checked  = 0;

    key_change_to_midi_events_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic key_kind_e classify_key(input int bit_idx, output int code);
        code = 0;
        if (bit_idx >= 24 && bit_idx <= 30) begin
            code = bit_idx - 24;
            return KEY_NOTE;
        end
        if (bit_idx >= 16 && bit_idx <= 21) begin
            code = bit_idx - 9;
            return KEY_NOTE;
        end
        if (bit_idx >= 8 && bit_idx <= 13) begin
            code = bit_idx + 5;
            return KEY_NOTE;
        end
        if (bit_idx <= 4) begin
            code = bit_idx + 19;
            return KEY_NOTE;
        end
        case (bit_idx)
            22: code = 0;
            14: code = 1;
            5:  code = 2;
            6:  code = 3;
            default: return KEY_UNMAPPED;
        endcase
        return KEY_BUTTON;
    endfunction

    // Works out the messages one report causes and queues them in bit order.
    function automatic int predict_report(input logic [31:0] word);
        logic [31:0] now_keys;
        midi_msg_t   batch[28];
        midi_msg_t   msg;
        key_kind_e   kind;
        int          code;
        int          note;
        int          count;
        now_keys = word & KCM_MAPPED_MASK;
        count = 0;
        for (int b = 0; b < 32; b++) begin
            kind = classify_key(b, code);
            if (kind != KEY_UNMAPPED && now_keys[b] != held_keys[b]) begin
                msg.value = cfg_velocity;
                msg.last  = 1'b0;
                if (kind == KEY_BUTTON) begin
                    if (now_keys[b]) begin
                        msg.status = KCM_ST_CTRL | {4'd0, cfg_channel};
                        msg.number = 7'(code);
                        batch[count] = msg;
                        count++;
                    end
                end else begin
                    note = int'(cfg_lowest) + code;
                    if (note > int'(KCM_NOTE_MAX)) begin
                        note = int'(KCM_NOTE_MAX);
                    end
                    msg.status = (now_keys[b] ? KCM_ST_NOTE_ON : KCM_ST_NOTE_OFF)
                                 | {4'd0, cfg_channel};
                    msg.number = 7'(note);
                    batch[count] = msg;
                    count++;
                end
            end
        end
        for (int i = 0; i < count; i++) begin
            msg = batch[i];
            msg.last = (i == count - 1);
            midi_expected.push_back(msg);
        end
        held_keys = now_keys;
        return count;
    endfunction

    task automatic send_report(input logic [31:0] word, output int n_msgs);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        do begin
            @(posedge i_clk);
        end while (o_s_tready !== 1'b1);
        n_msgs = predict_report(word);
        last_word = word;
        reports_sent++;
    endtask

    task automatic send_list(input logic [31:0] words[$]);
        int n;
        foreach (words[i]) begin
            send_report(words[i], n);
        end
    endtask

    // Reports with no message may still be in flight, so settle before going on.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (midi_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [6:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            KCM_REG_CHANNEL:  cfg_channel  = value[3:0];
            KCM_REG_VELOCITY: cfg_velocity = value;
            KCM_REG_LOWEST:   cfg_lowest   = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [3:0] channel, input logic [6:0] velocity,
                             input logic [6:0] lowest);
        write_reg(KCM_REG_CHANNEL, {3'd0, channel});
        write_reg(KCM_REG_VELOCITY, velocity);
        write_reg(KCM_REG_LOWEST, lowest);
    endtask

    // Mostly a few keys going up or down at a time, with some noise mixed in.
    function automatic logic [31:0] next_key_word();
        logic [31:0] word;
        int          pick;
        int          b;
        word = last_word;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            repeat ($urandom_range(1, 3)) begin
                do begin
                    b = $urandom_range(0, 31);
                end while (!KCM_MAPPED_MASK[b]);
                word[b] = ~word[b];
            end
        end else if (pick < 72) begin
            word = word ^ ($urandom() & ~KCM_MAPPED_MASK);
        end else if (pick < 90) begin
            word = $urandom();
        end else begin
            word = (pick[0]) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        return word;
    endfunction

    task automatic test_default_map();
        send_list('{32'h0000_0000, 32'h0100_0000, 32'h0000_0001, 32'h0040_0000,
                    32'h0000_0000, 32'h8080_8080, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_4060});
        wait_drained();
    endtask

    task automatic test_register_extremes();
        // Lowest note at the top saturates every note number.
        configure(4'd15, 7'd127, 7'd127);
        send_list('{32'h7F7F_7F7F, 32'h0000_0000});
        wait_drained();
        configure(4'd0, 7'd0, 7'd0);
        send_list('{32'hFFFF_FFFF, 32'h0000_0000});
        wait_drained();
        // A write to the spare index must leave every register alone.
        write_reg(KCM_REG_LOWEST, 7'd104);
        write_reg(REG_SPARE, 7'h7F);
        send_list('{32'h0000_001F, 32'h0100_0000, 32'h0000_0000});
        wait_drained();
    endtask

    task automatic test_random_reports(input int send_pct, input int recv_pct);
        int counted;
        int n;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        configure(4'($urandom_range(0, 15)), 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
        counted = 0;
        while (counted < PHASE_REPORTS) begin
            send_report(next_key_word(), n);
            if (n != 0) begin
                counted++;
            end
        end
        wait_drained();
    endtask

    task automatic test_output_hold_off();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        for (int i = 0; i < 8; i++) begin
            send_report(i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF, n);
        end
        wait_drained();
    endtask

    // Receiver side: checks each message transfer and drives tready.
    always @(posedge i_clk) begin
        midi_msg_t got;
        midi_msg_t want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            got.status = o_m_tdata[7:0];
            got.number = o_m_tdata[14:8];
            got.value  = o_m_tdata[21:15];
            got.last   = o_m_tlast;
            if (midi_expected.size() == 0) begin
                errors++;
                $display("%0t: unexpected message status %h number %h value %h last %b",
                         $time, got.status, got.number, got.value, got.last);
            end else begin
                want = midi_expected.pop_front();
                msgs_checked++;
                if (got !== want) begin
                    errors++;
                    $display("%0t: expected status %h number %h value %h last %b, ",
                             $time, want.status, want.number, want.value, want.last,
                             "actual status %h number %h value %h last %b",
                             got.status, got.number, got.value, got.last);
                end
            end
        end
        if (hold_start) begin
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
        if (hold_start || hold_left != 0) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready === 1'b1) || (o_m_tvalid === 1'b1 && i_m_tready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_map();
        test_register_extremes();
        test_random_reports(0, 0);
        test_random_reports(73, 0);
        test_random_reports(0, 73);
        test_random_reports(35, 35);
        test_output_hold_off();
        wait_drained();
        $display("Checked %0d MIDI messages from %0d key reports: default map,",
                 msgs_checked, reports_sent);
        $display("register extremes, four flow-control mixes and a long output hold-off.");
        if (errors == 0 && midi_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
sv/kcm_pkg.sv
sv/kcm_front.sv
sv/kcm_queue.sv
sv/kcm_back.sv
sv/key_change_to_midi_events_core.sv
verif/testbench.sv
